@@ src/fccm_pkg.sv @@
// Shared types and constants of the FAT16 cluster chain manager.
package fccm_pkg;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_EXTEND = 2'd2;
  localparam logic [1:0] REQ_COUNT  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSPC  = 2'd1;
  localparam logic [1:0] ST_BROKEN = 2'd2;

  localparam logic [15:0] END_MARK   = 16'hFFFF;
  localparam logic [15:0] END_LIMIT  = 16'hFFF0;
  localparam logic [14:0] APPEND_MAX = 15'd16384;
  localparam logic [9:0]  CLUSTER_BYTES = 10'd512;

  // Table write operations.
  localparam logic [2:0] WR_NONE      = 3'd0;
  localparam logic [2:0] WR_SCAN_ZERO = 3'd1;
  localparam logic [2:0] WR_PREV_SCAN = 3'd2;
  localparam logic [2:0] WR_PREV_END  = 3'd3;
  localparam logic [2:0] WR_CUR_ZERO  = 3'd4;
  localparam logic [2:0] WR_CUR_SCAN  = 3'd5;
  localparam logic [2:0] WR_SCAN_END  = 3'd6;

  // Result kinds.
  localparam logic [3:0] EM_ALLOC_FAIL = 4'd0;
  localparam logic [3:0] EM_ALLOC_OK   = 4'd1;
  localparam logic [3:0] EM_FREE_OK    = 4'd2;
  localparam logic [3:0] EM_FREE_BAD   = 4'd3;
  localparam logic [3:0] EM_COUNT      = 4'd4;
  localparam logic [3:0] EM_BROKEN     = 4'd5;
  localparam logic [3:0] EM_FULL       = 4'd6;
  localparam logic [3:0] EM_SEG        = 4'd7;
  localparam logic [3:0] EM_EMPTY      = 4'd8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] start_cluster;
    logic [31:0] byte_size;
    logic [14:0] append_bytes;
    logic [15:0] max_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cluster;
    logic [15:0] sector;
    logic [8:0]  seg_offset;
    logic [9:0]  seg_length;
    logic [15:0] count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       scan_rst;
    logic       scan_inc;
    logic       cnt_rst;
    logic       cnt_inc;
    logic       take_first;
    logic       rd_cur;
    logic [2:0] wr_op;
    logic       cur_from_data;
    logic       cur_from_scan;
    logic       steps_dec;
    logic       emit;
    logic [3:0] emit_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] new_type;
    logic [1:0] req_type;
    logic       is_free;
    logic       hit;
    logic       scan_last;
    logic       cnt_eq_lim;
    logic       n_zero;
    logic       cur_is_data;
    logic       nxt_end;
    logic       nxt_is_data;
    logic       steps_too_big;
    logic       steps_zero;
    logic       steps_one;
    logic       rem_zero;
    logic       off_full;
    logic       seg_last;
    logic       emitted;
  } dp_stat_t;

endpackage

@@ src/fccm_ctrl.sv @@
// Sequencing state machine of the cluster chain manager.
module fccm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fccm_pkg::dp_stat_t stat,
  output fccm_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import fccm_pkg::*;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CN_RD  = 5'd2;
  localparam logic [4:0] S_CN_EV  = 5'd3;
  localparam logic [4:0] S_CN_OUT = 5'd4;
  localparam logic [4:0] S_AL_RD  = 5'd5;
  localparam logic [4:0] S_AL_EV  = 5'd6;
  localparam logic [4:0] S_AL_END = 5'd7;
  localparam logic [4:0] S_FR_CHK = 5'd8;
  localparam logic [4:0] S_FR_RD  = 5'd9;
  localparam logic [4:0] S_FR_EV  = 5'd10;
  localparam logic [4:0] S_FR_OK  = 5'd11;
  localparam logic [4:0] S_EX_CHK = 5'd12;
  localparam logic [4:0] S_EX_RD  = 5'd13;
  localparam logic [4:0] S_EX_EV  = 5'd14;
  localparam logic [4:0] S_EX_SEG = 5'd15;
  localparam logic [4:0] S_EX_FRD = 5'd16;
  localparam logic [4:0] S_EX_FEV = 5'd17;
  localparam logic [4:0] S_EX_MRK = 5'd18;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.wr_op = WR_SCAN_ZERO;
        cmd.scan_inc = 1'b1;
        if (stat.scan_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.scan_rst = 1'b1;
          case (stat.new_type)
            REQ_FREE:   state_next = S_FR_CHK;
            REQ_EXTEND: state_next = S_EX_CHK;
            default:    state_next = S_CN_RD;
          endcase
        end
      end
      S_CN_RD: state_next = S_CN_EV;
      S_CN_EV: begin
        cmd.cnt_inc = stat.is_free;
        if (stat.hit || stat.scan_last) begin
          state_next = S_CN_OUT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next = S_CN_RD;
        end
      end
      S_CN_OUT: begin
        if (stat.req_type == REQ_ALLOC) begin
          if (stat.cnt_eq_lim) begin
            cmd.scan_rst = 1'b1;
            cmd.cnt_rst = 1'b1;
            state_next = S_AL_RD;
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_kind = EM_ALLOC_FAIL;
            state_next = S_IDLE;
          end
        end else begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_COUNT;
          state_next = S_IDLE;
        end
      end
      S_AL_RD: state_next = S_AL_EV;
      S_AL_EV: begin
        if (stat.is_free) begin
          cmd.cnt_inc = 1'b1;
          if (stat.n_zero) begin
            cmd.take_first = 1'b1;
          end else begin
            cmd.wr_op = WR_PREV_SCAN;
          end
        end
        if (stat.hit) begin
          state_next = S_AL_END;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next = S_AL_RD;
        end
      end
      S_AL_END: begin
        cmd.wr_op = WR_PREV_END;
        cmd.emit = 1'b1;
        cmd.emit_kind = EM_ALLOC_OK;
        state_next = S_IDLE;
      end
      S_FR_CHK: begin
        if (stat.cur_is_data) begin
          state_next = S_FR_RD;
        end else begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_FREE_BAD;
          state_next = S_IDLE;
        end
      end
      S_FR_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_FR_EV;
      end
      S_FR_EV: begin
        if (stat.nxt_end) begin
          cmd.wr_op = WR_CUR_ZERO;
          cmd.cnt_inc = 1'b1;
          state_next = S_FR_OK;
        end else if (!stat.nxt_is_data) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_FREE_BAD;
          state_next = S_IDLE;
        end else begin
          cmd.wr_op = WR_CUR_ZERO;
          cmd.cnt_inc = 1'b1;
          cmd.cur_from_data = 1'b1;
          state_next = S_FR_RD;
        end
      end
      S_FR_OK: begin
        cmd.emit = 1'b1;
        cmd.emit_kind = EM_FREE_OK;
        state_next = S_IDLE;
      end
      S_EX_CHK: begin
        if (!stat.cur_is_data || stat.steps_too_big) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_BROKEN;
          state_next = S_IDLE;
        end else if (stat.steps_zero) begin
          state_next = S_EX_SEG;
        end else begin
          state_next = S_EX_RD;
        end
      end
      S_EX_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_EX_EV;
      end
      S_EX_EV: begin
        if (!stat.nxt_is_data) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_BROKEN;
          state_next = S_IDLE;
        end else begin
          cmd.cur_from_data = 1'b1;
          cmd.steps_dec = 1'b1;
          state_next = stat.steps_one ? S_EX_SEG : S_EX_RD;
        end
      end
      S_EX_SEG: begin
        if (stat.rem_zero) begin
          if (!stat.emitted) begin
            cmd.emit = 1'b1;
            cmd.emit_kind = EM_EMPTY;
          end
          state_next = S_IDLE;
        end else if (stat.off_full) begin
          cmd.scan_rst = 1'b1;
          state_next = S_EX_FRD;
        end else begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_SEG;
          if (stat.seg_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EX_FRD: state_next = S_EX_FEV;
      S_EX_FEV: begin
        if (stat.is_free) begin
          cmd.wr_op = WR_CUR_SCAN;
          state_next = S_EX_MRK;
        end else if (stat.scan_last) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next = S_EX_FRD;
        end
      end
      S_EX_MRK: begin
        cmd.wr_op = WR_SCAN_END;
        cmd.cur_from_scan = 1'b1;
        state_next = S_EX_SEG;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/fccm_dp.sv @@
// Datapath of the cluster chain manager: link table, walk registers and result register.
module fccm_dp #(
  parameter int DATA_CLUSTERS = 4094
) (
  input  logic               clk,
  input  logic               rst,
  input  fccm_pkg::req_t     req,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  input  fccm_pkg::dp_cmd_t  cmd,
  output fccm_pkg::dp_stat_t stat,
  output logic               res_valid,
  output fccm_pkg::res_t     res
);
  import fccm_pkg::*;

  localparam int DEPTH = DATA_CLUSTERS + 2;
  localparam int AW = $clog2(DEPTH);
  localparam logic [16:0] DEPTH_V = 17'(DEPTH);
  localparam logic [22:0] DC_V = 23'(DATA_CLUSTERS);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;
  logic [15:0] sector_base;
  logic [15:0] scan, cur, prev, first, n;
  logic [23:0] limit;
  logic [22:0] steps;
  logic [9:0]  offset;
  logic [14:0] rem;
  logic        emitted;
  logic [1:0]  req_type;

  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [15:0]   wdata;
  logic [9:0]    avail, len;
  logic [31:0]   size_m1;
  logic [14:0]   add_sat;
  res_t          res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_base <= 16'd22;
    end else if (cfg_valid) begin
      sector_base <= cfg_data;
    end
  end

  assign raddr = cmd.rd_cur ? cur[AW-1:0] : scan[AW-1:0];

  always_comb begin
    we = 1'b1;
    waddr = scan[AW-1:0];
    wdata = 16'd0;
    case (cmd.wr_op)
      WR_SCAN_ZERO: begin
        waddr = scan[AW-1:0];
      end
      WR_PREV_SCAN: begin
        waddr = prev[AW-1:0];
        wdata = scan;
      end
      WR_PREV_END: begin
        waddr = prev[AW-1:0];
        wdata = END_MARK;
      end
      WR_CUR_ZERO: begin
        waddr = cur[AW-1:0];
      end
      WR_CUR_SCAN: begin
        waddr = cur[AW-1:0];
        wdata = scan;
      end
      WR_SCAN_END: begin
        wdata = END_MARK;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign size_m1 = req.byte_size - 32'd1;
  assign add_sat = (req.append_bytes > APPEND_MAX) ? APPEND_MAX : req.append_bytes;
  assign avail = CLUSTER_BYTES - offset;
  assign len = ({5'd0, avail} > rem) ? rem[9:0] : avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= 16'd0;
    end else if (cmd.scan_rst) begin
      scan <= 16'd2;
    end else if (cmd.scan_inc) begin
      scan <= scan + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type <= req.req_type;
      cur <= req.start_cluster;
      n <= 16'd0;
      limit <= (req.req_type == REQ_ALLOC) ? ({1'b0, req.byte_size[31:9]} + 24'd1)
                                           : {8'd0, req.max_count};
      rem <= add_sat;
      emitted <= 1'b0;
      if (req.byte_size == 32'd0) begin
        steps <= 23'd0;
        offset <= 10'd0;
      end else begin
        steps <= size_m1[31:9];
        offset <= {1'b0, size_m1[8:0]} + 10'd1;
      end
    end else begin
      if (cmd.cnt_rst) begin
        n <= 16'd0;
      end else if (cmd.cnt_inc) begin
        n <= n + 16'd1;
      end
      if (cmd.cur_from_data) begin
        cur <= rdata;
      end else if (cmd.cur_from_scan) begin
        cur <= scan;
        offset <= 10'd0;
      end
      if (cmd.steps_dec) begin
        steps <= steps - 23'd1;
      end
      if (cmd.emit && cmd.emit_kind == EM_SEG) begin
        rem <= rem - {5'd0, len};
        offset <= offset + len;
        emitted <= 1'b1;
      end
    end
    if (cmd.take_first) begin
      first <= scan;
      prev <= scan;
    end else if (cmd.wr_op == WR_PREV_SCAN) begin
      prev <= scan;
    end
  end

  always_comb begin
    stat.new_type = req.req_type;
    stat.req_type = req_type;
    stat.is_free = (rdata == 16'd0);
    stat.hit = stat.is_free && (({8'd0, n} + 24'd1) == limit);
    stat.scan_last = ({1'b0, scan} == DEPTH_V - 17'd1);
    stat.cnt_eq_lim = ({8'd0, n} == limit);
    stat.n_zero = (n == 16'd0);
    stat.cur_is_data = (cur >= 16'd2) && ({1'b0, cur} < DEPTH_V);
    stat.nxt_end = (rdata > END_LIMIT);
    stat.nxt_is_data = (rdata >= 16'd2) && ({1'b0, rdata} < DEPTH_V);
    stat.steps_too_big = (steps >= DC_V);
    stat.steps_zero = (steps == 23'd0);
    stat.steps_one = (steps == 23'd1);
    stat.rem_zero = (rem == 15'd0);
    stat.off_full = offset[9];
    stat.seg_last = ({5'd0, len} == rem);
    stat.emitted = emitted;
  end

  always_comb begin
    res_next = '0;
    res_next.last = 1'b1;
    case (cmd.emit_kind)
      EM_ALLOC_FAIL: begin
        res_next.status = ST_NOSPC;
        res_next.count = n;
      end
      EM_ALLOC_OK: begin
        res_next.cluster = first;
        res_next.sector = first + sector_base - 16'd2;
        res_next.count = n;
      end
      EM_FREE_OK: res_next.count = n;
      EM_FREE_BAD: begin
        res_next.status = ST_BROKEN;
        res_next.count = n;
      end
      EM_COUNT: res_next.count = n;
      EM_BROKEN: res_next.status = ST_BROKEN;
      EM_FULL: res_next.status = ST_NOSPC;
      EM_SEG: begin
        res_next.cluster = cur;
        res_next.sector = cur + sector_base - 16'd2;
        res_next.seg_offset = offset[8:0];
        res_next.seg_length = len;
        res_next.last = stat.seg_last;
      end
      default: res_next.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      res <= res_next;
    end
  end

endmodule

@@ src/fat_cluster_chain_manager_unit.sv @@
// A scan reads, then checks, each table entry in turn; free and extend walks do so per link.
// Count makes one table scan and allocate makes two; each scan may run through the whole table.
// Extend rescans from cluster 2 for each new cluster, so up to 32 scans per request.
// One request is handled at a time; busy is high until its final result is shown.
// After reset the link table is cleared entry by entry, with busy high.
// Results appear for one cycle with res_valid; the receiver cannot stall.
module fat_cluster_chain_manager_unit #(
  parameter int DATA_CLUSTERS = 4094
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  fccm_pkg::req_t  req,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  output logic            res_valid,
  output fccm_pkg::res_t  res
);
  import fccm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     start_ok;

  assign cfg_ready = 1'b1;
  assign start_ok = start;

  fccm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start_ok),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fccm_dp #(.DATA_CLUSTERS(DATA_CLUSTERS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

@@ src/fccm_checker.sv @@
// Port-level checks of the cluster chain manager, bound to the top level.
module fccm_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           res_valid,
  input fccm_pkg::res_t res
);
  import fccm_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result strobe after reset");
  a_rst_clear: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy while clearing the table");
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("transfer taken but block not busy");
  a_more: assert property (@(posedge clk) disable iff (rst)
      (res_valid && !res.last) |-> busy)
    else $error("idle before the final result");
  a_stat: assert property (@(posedge clk) disable iff (rst)
      res_valid |-> (res.status == ST_OK || res.status == ST_NOSPC || res.status == ST_BROKEN))
    else $error("undefined status code");

endmodule

bind fat_cluster_chain_manager_unit fccm_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .res_valid (res_valid),
  .res       (res)
);
